// ----- sv/osa_pkg.sv -----
// ----------------------------------------------------------------------------
// osa_pkg
// Shared constants, types and helpers for the optimal string alignment
// distance engine.
// ----------------------------------------------------------------------------
package osa_pkg;

  // Longest string that is kept; longer strings flag too_long
  localparam int MAX_LEN    = 32;
  localparam int SYM_W      = 8;
  localparam int ADDR_W     = $clog2(MAX_LEN);
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  // A cost never exceeds the longer length
  localparam int COST_W     = LEN_W;
  localparam int COST_DEPTH = MAX_LEN + 1;
  localparam int COST_AW    = $clog2(COST_DEPTH);
  localparam int DIST_W     = 6;
  localparam int DIST_MAX   = 63;

  // Distance sequencer states
  typedef enum logic [1:0] {
    DP_IDLE,
    DP_INIT,
    DP_ROW,
    DP_CELL
  } dp_state_t;

  // Read request to a text store
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } text_rd_t;

  // Cost row store control; one entry holds {row i-1, row i-2} of a column
  typedef struct packed {
    logic                re;
    logic [COST_AW-1:0]  raddr;
    logic                we;
    logic [COST_AW-1:0]  waddr;
    logic [2*COST_W-1:0] wdata;
  } cost_ctl_t;

  // Clamp a cost to the output width
  function automatic logic [DIST_W-1:0] sat_dist(input logic [COST_W-1:0] v);
    logic [DIST_W-1:0] res;
    if (int'(v) > DIST_MAX) begin
      res = DIST_W'(DIST_MAX);
    end else begin
      res = DIST_W'(v);
    end
    return res;
  endfunction

endpackage

// ----- sv/osa_ram.sv -----
// ----------------------------------------------------------------------------
// osa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module osa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, data held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/osa_cell.sv -----
// ----------------------------------------------------------------------------
// osa_cell
// One cell of the alignment recurrence: match, edit and adjacent swap.
// ----------------------------------------------------------------------------
module osa_cell (
  input  logic [osa_pkg::SYM_W-1:0]  a,
  input  logic [osa_pkg::SYM_W-1:0]  a_prev,
  input  logic [osa_pkg::SYM_W-1:0]  b,
  input  logic [osa_pkg::SYM_W-1:0]  b_prev,
  input  logic                       swap_ok,
  input  logic [osa_pkg::COST_W-1:0] up,
  input  logic [osa_pkg::COST_W-1:0] up_left,
  input  logic [osa_pkg::COST_W-1:0] left,
  input  logic [osa_pkg::COST_W-1:0] up2_left2,
  output logic [osa_pkg::COST_W-1:0] cost
);
  import osa_pkg::*;

  logic [COST_W-1:0] min_ul;
  logic [COST_W-1:0] min_all;
  logic [COST_W-1:0] base;
  logic [COST_W-1:0] swap_cost;

  // Cheapest of delete, insert, substitute
  assign min_ul  = (up < left) ? up : left;
  assign min_all = (min_ul < up_left) ? min_ul : up_left;
  assign base    = (a == b) ? up_left : min_all + COST_W'(1);

  // Adjacent transposition
  assign swap_cost = up2_left2 + COST_W'(1);

  always_comb begin
    cost = base;
    if (swap_ok && (a == b_prev) && (a_prev == b) && (swap_cost < base)) begin
      cost = swap_cost;
    end
  end

endmodule

// ----- sv/osa_dp.sv -----
// ----------------------------------------------------------------------------
// osa_dp
// Distance sequencer: walks the cost matrix one cell per cycle plus a row
// setup state, keeping two previous rows as read-modify-write cost entries.
// ----------------------------------------------------------------------------
module osa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [osa_pkg::LEN_W-1:0]    n_len,
  input  logic [osa_pkg::LEN_W-1:0]    m_len,
  input  logic [osa_pkg::SYM_W-1:0]    first_q,
  input  logic [osa_pkg::SYM_W-1:0]    second_q,
  input  logic [2*osa_pkg::COST_W-1:0] cost_q,
  output osa_pkg::text_rd_t            first_rd,
  output osa_pkg::text_rd_t            second_rd,
  output osa_pkg::cost_ctl_t           cost_ctl,
  output logic                         busy,
  output logic                         done,
  output logic [osa_pkg::COST_W-1:0]   result_cost
);
  import osa_pkg::*;

  dp_state_t         state_r, state_nxt;
  logic [LEN_W-1:0]  i_r, i_nxt;
  logic [LEN_W-1:0]  j_r, j_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt;
  logic [LEN_W-1:0]  m_r, m_nxt;
  logic [SYM_W-1:0]  a_prev_r, a_prev_nxt;
  logic [SYM_W-1:0]  b_prev_r, b_prev_nxt;
  logic [COST_W-1:0] up_m1_r, up_m1_nxt;
  logic [COST_W-1:0] up2_m1_r, up2_m1_nxt;
  logic [COST_W-1:0] up2_m2_r, up2_m2_nxt;
  logic [COST_W-1:0] cur_m1_r, cur_m1_nxt;
  logic              done_r, done_nxt;
  logic [COST_W-1:0] dist_r, dist_nxt;

  logic [COST_W-1:0] up;
  logic [COST_W-1:0] up2;
  logic [COST_W-1:0] cell_cost;
  logic              swap_ok;

  assign up      = cost_q[2*COST_W-1:COST_W];
  assign up2     = cost_q[COST_W-1:0];
  assign swap_ok = (i_r > LEN_W'(1)) && (j_r > LEN_W'(1));

  osa_cell u_cell (
    .a         (first_q),
    .a_prev    (a_prev_r),
    .b         (second_q),
    .b_prev    (b_prev_r),
    .swap_ok   (swap_ok),
    .up        (up),
    .up_left   (up_m1_r),
    .left      (cur_m1_r),
    .up2_left2 (up2_m2_r),
    .cost      (cell_cost)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DP_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    n_r      <= n_nxt;
    m_r      <= m_nxt;
    a_prev_r <= a_prev_nxt;
    b_prev_r <= b_prev_nxt;
    up_m1_r  <= up_m1_nxt;
    up2_m1_r <= up2_m1_nxt;
    up2_m2_r <= up2_m2_nxt;
    cur_m1_r <= cur_m1_nxt;
    dist_r   <= dist_nxt;
  end

  // Next state and memory control
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    n_nxt      = n_r;
    m_nxt      = m_r;
    a_prev_nxt = a_prev_r;
    b_prev_nxt = b_prev_r;
    up_m1_nxt  = up_m1_r;
    up2_m1_nxt = up2_m1_r;
    up2_m2_nxt = up2_m2_r;
    cur_m1_nxt = cur_m1_r;
    done_nxt   = 1'b0;
    dist_nxt   = dist_r;
    first_rd   = '0;
    second_rd  = '0;
    cost_ctl   = '0;

    unique case (state_r)
      DP_IDLE: begin
        if (go) begin
          n_nxt     = n_len;
          m_nxt     = m_len;
          j_nxt     = LEN_W'(1);
          state_nxt = DP_INIT;
        end
      end

      // Row zero: column j costs j
      DP_INIT: begin
        cost_ctl.we    = 1'b1;
        cost_ctl.waddr = COST_AW'(j_r);
        cost_ctl.wdata = {COST_W'(j_r), COST_W'(0)};
        if (j_r == m_r) begin
          i_nxt     = LEN_W'(1);
          state_nxt = DP_ROW;
        end else begin
          j_nxt = j_r + LEN_W'(1);
        end
      end

      // Row setup: fetch a, first column operands
      DP_ROW: begin
        first_rd.re    = 1'b1;
        first_rd.addr  = ADDR_W'(i_r - LEN_W'(1));
        second_rd.re   = 1'b1;
        second_rd.addr = '0;
        cost_ctl.re    = 1'b1;
        cost_ctl.raddr = COST_AW'(1);
        j_nxt          = LEN_W'(1);
        cur_m1_nxt     = COST_W'(i_r);
        up_m1_nxt      = COST_W'(i_r - LEN_W'(1));
        up2_m1_nxt     = COST_W'(i_r - LEN_W'(2));
        state_nxt      = DP_CELL;
      end

      // One cell per cycle; write back {cur, up} to the same column
      DP_CELL: begin
        cost_ctl.we    = 1'b1;
        cost_ctl.waddr = COST_AW'(j_r);
        cost_ctl.wdata = {cell_cost, up};
        up_m1_nxt      = up;
        up2_m2_nxt     = up2_m1_r;
        up2_m1_nxt     = up2;
        cur_m1_nxt     = cell_cost;
        b_prev_nxt     = second_q;
        if (j_r == m_r) begin
          if (i_r == n_r) begin
            done_nxt  = 1'b1;
            dist_nxt  = cell_cost;
            state_nxt = DP_IDLE;
          end else begin
            i_nxt      = i_r + LEN_W'(1);
            a_prev_nxt = first_q;
            state_nxt  = DP_ROW;
          end
        end else begin
          second_rd.re   = 1'b1;
          second_rd.addr = ADDR_W'(j_r);
          cost_ctl.re    = 1'b1;
          cost_ctl.raddr = COST_AW'(j_r + LEN_W'(1));
          j_nxt          = j_r + LEN_W'(1);
        end
      end

      default: begin
        state_nxt = DP_IDLE;
      end
    endcase
  end

  assign busy        = (state_r != DP_IDLE);
  assign done        = done_r;
  assign result_cost = dist_r;

endmodule

// ----- sv/osa_edit_distance.sv -----
// ----------------------------------------------------------------------------
// osa_edit_distance
// Loads two byte strings and reports their optimal string alignment distance.
// ----------------------------------------------------------------------------
// Loading: one word per cycle, busy stays low.
// When a string is empty or too long, the result is registered directly from
// the word that closes the pair; else it comes from the one-cell-per-cycle walk
// through the cost row memory, and busy is high meanwhile.
// Reset clears lengths, close flags, overflow flag and the sequencer.
// The result strobe out_valid lasts one cycle and cannot be stalled.
module osa_edit_distance (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_which_string,
  input  logic [osa_pkg::SYM_W-1:0]    in_symbol,
  input  logic                         in_is_empty,
  input  logic                         in_last_symbol,
  output logic                         out_valid,
  output logic [osa_pkg::DIST_W-1:0]   out_distance,
  output logic                         out_too_long
);
  import osa_pkg::*;

  logic [LEN_W-1:0]  first_len_r, first_len_nxt;
  logic [LEN_W-1:0]  second_len_r, second_len_nxt;
  logic              first_closed_r, first_closed_nxt;
  logic              second_closed_r, second_closed_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_distance_r, out_distance_nxt;
  logic              out_too_long_r, out_too_long_nxt;

  logic              accept;
  logic              sel_closed;
  logic [LEN_W-1:0]  sel_len;
  logic              take;
  logic              has_room;
  logic              store;
  logic              close;
  logic              go;
  logic              dp_busy;
  logic              dp_done;
  logic [COST_W-1:0] dp_dist;

  text_rd_t          first_rd;
  text_rd_t          second_rd;
  cost_ctl_t         cost_ctl;
  logic [SYM_W-1:0]  first_q;
  logic [SYM_W-1:0]  second_q;
  logic [2*COST_W-1:0] cost_q;

  // Word decode
  assign accept     = start && !busy;
  assign sel_closed = in_which_string ? second_closed_r : first_closed_r;
  assign sel_len    = in_which_string ? second_len_r : first_len_r;
  assign take       = accept && !sel_closed;
  assign has_room   = (sel_len < LEN_W'(MAX_LEN));
  assign store      = take && !in_is_empty && has_room;
  assign close      = take && (in_is_empty || in_last_symbol);

  // Pair bookkeeping and short-cut results
  always_comb begin
    first_len_nxt     = first_len_r;
    second_len_nxt    = second_len_r;
    first_closed_nxt  = first_closed_r;
    second_closed_nxt = second_closed_r;
    ovf_nxt           = ovf_r;
    out_valid_nxt     = 1'b0;
    out_distance_nxt  = out_distance_r;
    out_too_long_nxt  = out_too_long_r;
    go                = 1'b0;

    if (store && !in_which_string) first_len_nxt  = first_len_r + LEN_W'(1);
    if (store && in_which_string)  second_len_nxt = second_len_r + LEN_W'(1);
    if (take && !in_is_empty && !has_room) ovf_nxt = 1'b1;
    if (close && !in_which_string) first_closed_nxt  = 1'b1;
    if (close && in_which_string)  second_closed_nxt = 1'b1;

    if (take && first_closed_nxt && second_closed_nxt) begin
      if (ovf_nxt) begin
        out_valid_nxt    = 1'b1;
        out_distance_nxt = '0;
        out_too_long_nxt = 1'b1;
      end else if (first_len_nxt == '0) begin
        out_valid_nxt    = 1'b1;
        out_distance_nxt = sat_dist(COST_W'(second_len_nxt));
        out_too_long_nxt = 1'b0;
      end else if (second_len_nxt == '0) begin
        out_valid_nxt    = 1'b1;
        out_distance_nxt = sat_dist(COST_W'(first_len_nxt));
        out_too_long_nxt = 1'b0;
      end else begin
        go = 1'b1;
      end
      first_len_nxt     = '0;
      second_len_nxt    = '0;
      first_closed_nxt  = 1'b0;
      second_closed_nxt = 1'b0;
      ovf_nxt           = 1'b0;
    end

    // Sequencer result
    if (dp_done) begin
      out_valid_nxt    = 1'b1;
      out_distance_nxt = sat_dist(dp_dist);
      out_too_long_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_len_r     <= '0;
      second_len_r    <= '0;
      first_closed_r  <= 1'b0;
      second_closed_r <= 1'b0;
      ovf_r           <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      first_len_r     <= first_len_nxt;
      second_len_r    <= second_len_nxt;
      first_closed_r  <= first_closed_nxt;
      second_closed_r <= second_closed_nxt;
      ovf_r           <= ovf_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_distance_r <= out_distance_nxt;
    out_too_long_r <= out_too_long_nxt;
  end

  // Text stores
  osa_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_LEN)
  ) u_first_text (
    .clk   (clk),
    .we    (store && !in_which_string),
    .waddr (ADDR_W'(first_len_r)),
    .wdata (in_symbol),
    .re    (first_rd.re),
    .raddr (first_rd.addr),
    .rdata (first_q)
  );

  osa_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_LEN)
  ) u_second_text (
    .clk   (clk),
    .we    (store && in_which_string),
    .waddr (ADDR_W'(second_len_r)),
    .wdata (in_symbol),
    .re    (second_rd.re),
    .raddr (second_rd.addr),
    .rdata (second_q)
  );

  // Cost rows: per column, previous and second previous row
  osa_ram #(
    .WIDTH (2*COST_W),
    .DEPTH (COST_DEPTH)
  ) u_cost_rows (
    .clk   (clk),
    .we    (cost_ctl.we),
    .waddr (cost_ctl.waddr),
    .wdata (cost_ctl.wdata),
    .re    (cost_ctl.re),
    .raddr (cost_ctl.raddr),
    .rdata (cost_q)
  );

  // Lengths include a symbol stored by the closing word
  osa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .n_len       (first_len_r + LEN_W'(store && !in_which_string)),
    .m_len       (second_len_r + LEN_W'(store && in_which_string)),
    .first_q     (first_q),
    .second_q    (second_q),
    .cost_q      (cost_q),
    .first_rd    (first_rd),
    .second_rd   (second_rd),
    .cost_ctl    (cost_ctl),
    .busy        (dp_busy),
    .done        (dp_done),
    .result_cost (dp_dist)
  );

  assign busy         = dp_busy;
  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_too_long = out_too_long_r;

endmodule

// ----- tb/sv/osa_distance_checker.sv -----
// ----------------------------------------------------------------------------
// osa_distance_checker
// Watches the word and result channels of the string distance engine, keeps
// its own copy of both string stores, predicts each distance and checks every
// result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module osa_distance_checker
  import osa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_which_string,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_is_empty,
  input  logic              in_last_symbol,
  input  logic              out_valid,
  input  logic [DIST_W-1:0] out_distance,
  input  logic              out_too_long,
  output int                mismatch_count,
  output int                pending_scores
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } score_t;

  // Scores predicted but not yet seen on the result port, oldest first
  score_t expected_scores[$];

  // Shadow of the two string stores
  logic [SYM_W-1:0] first_syms[MAX_LEN];
  logic [SYM_W-1:0] second_syms[MAX_LEN];
  int unsigned      first_len;
  int unsigned      second_len;
  bit               first_done;
  bit               second_done;
  bit               too_long_seen;

  // Full-matrix OSA distance over the loaded symbols
  function automatic int unsigned alignment_cost();
    int unsigned grid[MAX_LEN+1][MAX_LEN+1];
    int unsigned i;
    int unsigned j;
    int unsigned v;
    for (j = 0; j <= second_len; j++) grid[0][j] = j;
    for (i = 1; i <= first_len; i++) begin
      grid[i][0] = i;
      for (j = 1; j <= second_len; j++) begin
        if (first_syms[i-1] == second_syms[j-1]) begin
          v = grid[i-1][j-1];
        end else begin
          v = grid[i-1][j];
          if (grid[i][j-1] < v) v = grid[i][j-1];
          if (grid[i-1][j-1] < v) v = grid[i-1][j-1];
          v = v + 1;
        end
        // adjacent swap
        if (i > 1 && j > 1 && first_syms[i-1] == second_syms[j-2] &&
            first_syms[i-2] == second_syms[j-1] && grid[i-2][j-2] + 1 < v) begin
          v = grid[i-2][j-2] + 1;
        end
        grid[i][j] = v;
      end
    end
    return grid[first_len][second_len];
  endfunction

  function automatic void clear_pair();
    first_len     = 0;
    second_len    = 0;
    first_done    = 1'b0;
    second_done   = 1'b0;
    too_long_seen = 1'b0;
  endfunction

  // Apply one accepted word; queue a score when the pair closes
  function automatic void take_word(bit to_second, logic [SYM_W-1:0] sym,
                                    bit empty, bit last);
    bit          done;
    int unsigned n;
    int unsigned cost;
    score_t      score;
    done = to_second ? second_done : first_done;
    if (done) return;   // closed string: word is ignored
    n = to_second ? second_len : first_len;
    if (empty) begin
      done = 1'b1;      // empty mark wins over last_symbol
    end else begin
      if (n < MAX_LEN) begin
        if (to_second) second_syms[n] = sym;
        else first_syms[n] = sym;
        n++;
      end else begin
        too_long_seen = 1'b1;
      end
      if (last) done = 1'b1;
    end
    if (to_second) begin
      second_done = done;
      second_len  = n;
    end else begin
      first_done = done;
      first_len  = n;
    end
    if (!(first_done && second_done)) return;
    if (too_long_seen) begin
      score.distance = '0;
      score.too_long = 1'b1;
    end else begin
      cost = alignment_cost();
      score.distance = (cost > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(cost);
      score.too_long = 1'b0;
    end
    expected_scores.push_back(score);
    clear_pair();
  endfunction

  initial begin
    mismatch_count = 0;
    pending_scores = 0;
    clear_pair();
  end

  // Results first: a result never belongs to a word taken at the same edge
  always @(posedge clk) begin
    score_t exp_score;
    if (!rst_n) begin
      clear_pair();
    end else begin
      if (out_valid) begin
        if (expected_scores.size() == 0) begin
          $error("unexpected result: distance %0d too_long %0b",
                 out_distance, out_too_long);
          mismatch_count++;
        end else begin
          exp_score = expected_scores.pop_front();
          if (out_distance !== exp_score.distance) begin
            $error("distance: expected %0d, got %0d", exp_score.distance, out_distance);
            mismatch_count++;
          end
          if (out_too_long !== exp_score.too_long) begin
            $error("too_long: expected %0b, got %0b", exp_score.too_long, out_too_long);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        take_word(in_which_string, in_symbol, in_is_empty, in_last_symbol);
      end
    end
    pending_scores = expected_scores.size();
  end

endmodule

// ----- tb/sv/osa_edit_distance_test.sv -----
// ----------------------------------------------------------------------------
// osa_edit_distance_test
// Drives string pairs into the distance engine: a directed set of corner
// cases, then random pairs (mostly edited copies, some unrelated, empty,
// full-length or too long, plus ignored and stray words) under several
// sender idle rates. Checking is done by osa_distance_checker.
// ----------------------------------------------------------------------------
module osa_edit_distance_test;
  import osa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit FIRST_TEXT  = 1'b0;
  localparam bit SECOND_TEXT = 1'b1;
  localparam int WORDS_PER_PHASE = 135;
  // Longest compute with n = m = MAX_LEN, plus margin
  localparam int DRAIN_CYCLES = MAX_LEN * (MAX_LEN + 2) + 16;
  // Watchdog limit, well above the slowest correct run
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_FULL_VS_EMPTY,
    SHAPE_FIRST_OVER,
    SHAPE_FULL_PAIR,
    SHAPE_SECOND_OVER
  } pair_shape_t;

  typedef enum int {
    EDIT_SWAP,
    EDIT_SUBST,
    EDIT_INSERT,
    EDIT_DELETE
  } edit_kind_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start;
  logic              busy;
  logic              in_which_string;
  logic [SYM_W-1:0]  in_symbol;
  logic              in_is_empty;
  logic              in_last_symbol;
  logic              out_valid;
  logic [DIST_W-1:0] out_distance;
  logic              out_too_long;
  int                mismatch_count;
  int                pending_scores;

  int               idle_pct;
  int               items_sent;
  int               cycle_count;
  logic [SYM_W-1:0] str_first[$];
  logic [SYM_W-1:0] str_second[$];
  int               pos_of[2];
  bit               closed_of[2];
  bit               by_mark[2];

  osa_edit_distance DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_which_string (in_which_string),
    .in_symbol       (in_symbol),
    .in_is_empty     (in_is_empty),
    .in_last_symbol  (in_last_symbol),
    .out_valid       (out_valid),
    .out_distance    (out_distance),
    .out_too_long    (out_too_long)
  );

  osa_distance_checker score_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_which_string (in_which_string),
    .in_symbol       (in_symbol),
    .in_is_empty     (in_is_empty),
    .in_last_symbol  (in_last_symbol),
    .out_valid       (out_valid),
    .out_distance    (out_distance),
    .out_too_long    (out_too_long),
    .mismatch_count  (mismatch_count),
    .pending_scores  (pending_scores)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // One word: optional idle gap, then hold start until busy is low at an edge
  task automatic send_word(input bit to_second, input logic [SYM_W-1:0] sym,
                           input bit empty, input bit last, input bit counted);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start           <= 1'b1;
    in_which_string <= to_second;
    in_symbol       <= sym;
    in_is_empty     <= empty;
    in_last_symbol  <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (counted) items_sent++;
  endtask

  // Stop sending until every predicted score has come back
  task automatic wait_for_scores();
    @(negedge clk);
    start <= 1'b0;
    while (pending_scores != 0) @(negedge clk);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol(bit narrow);
    // narrow alphabet makes matches and swaps common
    return narrow ? SYM_W'("a") + SYM_W'($urandom_range(3)) : SYM_W'($urandom_range(255));
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 80) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, MAX_LEN - 1);
    if (r < 95) return MAX_LEN;
    return $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
  endfunction

  task automatic build_pair(input pair_shape_t shape);
    int         r;
    int         p;
    bit         narrow;
    edit_kind_t kind;
    logic [SYM_W-1:0] t;
    narrow = 1'($urandom_range(1));
    str_first.delete();
    str_second.delete();
    case (shape)
      SHAPE_RANDOM: begin
        repeat (pick_length()) str_first.push_back(pick_symbol(narrow));
        r = $urandom_range(99);
        if (r < 60) begin
          // edited copy: a few swaps, substitutions, insertions, deletions
          str_second = str_first;
          repeat ($urandom_range(3)) begin
            kind = edit_kind_t'($urandom_range(3));
            p = (str_second.size() == 0) ? 0 : $urandom_range(str_second.size() - 1);
            case (kind)
              EDIT_SWAP: begin
                if (p + 1 < str_second.size()) begin
                  t = str_second[p];
                  str_second[p] = str_second[p+1];
                  str_second[p+1] = t;
                end
              end
              EDIT_SUBST: begin
                if (str_second.size() > 0) str_second[p] = pick_symbol(narrow);
              end
              EDIT_INSERT: str_second.insert(p, pick_symbol(narrow));
              EDIT_DELETE: begin
                if (str_second.size() > 0) str_second.delete(p);
              end
              default: ;
            endcase
          end
        end else if (r < 85) begin
          repeat (pick_length()) str_second.push_back(pick_symbol(narrow));
        end else if (r < 93) begin
          str_second = str_first;
        end
      end
      SHAPE_FULL_VS_EMPTY: begin
        repeat (MAX_LEN) str_first.push_back(pick_symbol(1'b0));
      end
      SHAPE_FIRST_OVER: begin
        repeat ($urandom_range(MAX_LEN + 1, MAX_LEN + 3)) str_first.push_back(pick_symbol(1'b0));
        repeat (pick_length()) str_second.push_back(pick_symbol(1'b0));
      end
      SHAPE_FULL_PAIR: begin
        repeat (MAX_LEN) str_first.push_back(pick_symbol(1'b0));
        repeat (MAX_LEN) str_second.push_back(pick_symbol(1'b0));
      end
      SHAPE_SECOND_OVER: begin
        repeat ($urandom_range(1, 4)) str_first.push_back(pick_symbol(narrow));
        repeat ($urandom_range(MAX_LEN + 1, MAX_LEN + 3)) str_second.push_back(pick_symbol(narrow));
      end
      default: ;
    endcase
  endtask

  // Next word of one string: a symbol, or the empty mark that closes it
  task automatic step_string(input bit to_second);
    int               n;
    logic [SYM_W-1:0] sym;
    n = to_second ? str_second.size() : str_first.size();
    if (pos_of[to_second] < n) begin
      sym = to_second ? str_second[pos_of[to_second]] : str_first[pos_of[to_second]];
      pos_of[to_second]++;
      closed_of[to_second] = by_mark[to_second] && pos_of[to_second] == n;
      send_word(to_second, sym, 1'b0, closed_of[to_second], 1'b1);
    end else begin
      send_word(to_second, SYM_W'($urandom_range(255)), 1'b1, 1'($urandom_range(1)), 1'b1);
      closed_of[to_second] = 1'b1;
    end
  endtask

  // Interleave the two strings at random; now and then poke the closed one
  task automatic run_pair();
    bit to_second;
    for (int s = 0; s < 2; s++) begin
      pos_of[s]    = 0;
      closed_of[s] = 1'b0;
      by_mark[s]   = $urandom_range(99) < 80;
    end
    while (!(closed_of[0] && closed_of[1])) begin
      if (closed_of[FIRST_TEXT]) to_second = SECOND_TEXT;
      else if (closed_of[SECOND_TEXT]) to_second = FIRST_TEXT;
      else to_second = 1'($urandom_range(1));
      if (closed_of[!to_second] && $urandom_range(99) < 8) begin
        send_word(!to_second, SYM_W'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'b0);
      end
      step_string(to_second);
    end
  endtask

  initial begin
    int phase_goal;
    start           = 1'b0;
    in_which_string = 1'b0;
    in_symbol       = '0;
    in_is_empty     = 1'b0;
    in_last_symbol  = 1'b0;
    idle_pct        = 0;
    items_sent      = 0;
    cycle_count     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // both strings empty
    send_word(FIRST_TEXT, 8'h00, 1'b1, 1'b0, 1'b1);
    send_word(SECOND_TEXT, 8'hFF, 1'b1, 1'b1, 1'b1);
    // single adjacent swap
    send_word(FIRST_TEXT, "a", 1'b0, 1'b0, 1'b1);
    send_word(SECOND_TEXT, "b", 1'b0, 1'b0, 1'b1);
    send_word(FIRST_TEXT, "b", 1'b0, 1'b1, 1'b1);
    send_word(SECOND_TEXT, "a", 1'b0, 1'b1, 1'b1);
    // word for an already closed string is dropped
    send_word(FIRST_TEXT, "x", 1'b0, 1'b1, 1'b1);
    send_word(FIRST_TEXT, "y", 1'b0, 1'b1, 1'b1);
    send_word(SECOND_TEXT, "x", 1'b0, 1'b0, 1'b1);
    send_word(SECOND_TEXT, 8'h80, 1'b0, 1'b1, 1'b1);
    // empty mark after symbols keeps them, beats last_symbol
    send_word(FIRST_TEXT, "c", 1'b0, 1'b0, 1'b1);
    send_word(FIRST_TEXT, "d", 1'b0, 1'b0, 1'b1);
    send_word(FIRST_TEXT, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_word(SECOND_TEXT, "d", 1'b0, 1'b0, 1'b1);
    send_word(SECOND_TEXT, "c", 1'b0, 1'b1, 1'b1);
    // byte extremes
    send_word(FIRST_TEXT, 8'h00, 1'b0, 1'b0, 1'b1);
    send_word(FIRST_TEXT, 8'h7F, 1'b0, 1'b1, 1'b1);
    send_word(SECOND_TEXT, 8'hFF, 1'b0, 1'b1, 1'b1);
    // second string closes first
    send_word(SECOND_TEXT, 8'h55, 1'b1, 1'b0, 1'b1);
    send_word(FIRST_TEXT, "q", 1'b0, 1'b1, 1'b1);
    // restricted swap: "ca" vs "abc" costs 3, not 2
    send_word(FIRST_TEXT, "c", 1'b0, 1'b0, 1'b1);
    send_word(FIRST_TEXT, "a", 1'b0, 1'b1, 1'b1);
    send_word(SECOND_TEXT, "a", 1'b0, 1'b0, 1'b1);
    send_word(SECOND_TEXT, "b", 1'b0, 1'b0, 1'b1);
    send_word(SECOND_TEXT, "c", 1'b0, 1'b1, 1'b1);
    wait_for_scores();

    // random pairs under several sender idle rates
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 69;
        2:       idle_pct = 27;
        default: idle_pct = 0;
      endcase
      phase_goal = items_sent + WORDS_PER_PHASE;
      build_pair(pair_shape_t'(phase + 1));
      run_pair();
      while (items_sent < phase_goal) begin
        if ($urandom_range(99) < 5) begin
          // stray words with random fields
          repeat ($urandom_range(1, 3)) begin
            send_word(1'($urandom_range(1)), SYM_W'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
          end
        end else begin
          build_pair(SHAPE_RANDOM);
          run_pair();
        end
      end
      wait_for_scores();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_scores == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
